FILE: hw/rtl/ajb_pkg.sv
package ajb_pkg;

    localparam int RING_DEPTH_DEF = 16;
    localparam int MAX_PACKET     = 2047;
    localparam int MAX_RESULTS    = 16;
    localparam int PERCENT_BASE   = 100;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CMD_W      = 2;
    localparam int LEN_W      = 11;
    localparam int REQ_W      = 12;
    localparam int SLOT_W     = 4;
    localparam int DEPTH_W    = 16;
    localparam int PCT_W      = 8;
    localparam int DROP_W     = 5;
    localparam int TSLOT_W    = 5;
    localparam int STATUS_W   = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SEG_CNT_W  = $clog2(MAX_RESULTS + 1);

    // divide by the percent base through a scaled reciprocal
    localparam int PROD_W      = DEPTH_W + PCT_W;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 26;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(PERCENT_BASE) - 64'd1) / 64'(PERCENT_BASE);
    localparam logic [RECIP_W-1:0] PCT_RECIP = RECIP_W'(RECIP_FULL);
    localparam int QUOT_FULL_W = PROD_W + RECIP_W;
    localparam int QUOT_W      = QUOT_FULL_W - RECIP_SHIFT;
    localparam int GROWN_W     = QUOT_W + 1;

    localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST = DEPTH_W'(160);
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = DEPTH_W'(1600);
    localparam logic [PCT_W-1:0]   UPSCALE_RST   = PCT_W'(20);
    localparam logic [DROP_W-1:0]  DROP_RST      = DROP_W'(1);
    localparam logic [TSLOT_W-1:0] TSLOT_RST     = TSLOT_W'(0);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_DEPTH  = 3'd0,
        CFG_MAX_DEPTH  = 3'd1,
        CFG_UPSCALE    = 3'd2,
        CFG_DROP_COUNT = 3'd3,
        CFG_TIME_SLOT  = 3'd4
    } cfg_index_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_PUT_EMPTY,
        OP_READ,
        OP_READ_EMPTY,
        OP_START,
        OP_STOP
    } op_kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_INACTIVE  = 2'd0,
        MODE_FIRST_BUF = 2'd1,
        MODE_BUFFERING = 2'd2,
        MODE_SENDING   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED      = 3'd0,
        ST_STORED_DROP = 3'd1,
        ST_IGNORED     = 3'd2,
        ST_NOT_SENDING = 3'd3,
        ST_UNDERRUN    = 3'd4,
        ST_SEGMENT     = 3'd5,
        ST_STARTED     = 3'd6,
        ST_STOPPED     = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_EXEC,
        BK_DROP_RD,
        BK_DROP_UPD,
        BK_STORE,
        BK_SEG_RD,
        BK_SEG_EMIT,
        BK_UND_MUL,
        BK_UND_DIV,
        BK_UND_APPLY
    } bk_state_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [LEN_W-1:0]  plen;
        logic [REQ_W-1:0]  req;
    } op_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] min_depth;
        logic [DEPTH_W-1:0] max_depth;
        logic [PCT_W-1:0]   upscale_percent;
        logic [DROP_W-1:0]  drop_count;
        logic [TSLOT_W-1:0] time_slot;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot_index;
        logic [LEN_W-1:0]   source_offset;
        logic [REQ_W-1:0]   dest_offset;
        logic [LEN_W-1:0]   segment_length;
        logic [TSLOT_W-1:0] out_slot;
        mode_t              buffer_state;
        logic               last;
    } res_t;

endpackage

FILE: hw/rtl/ajb_front.sv
module ajb_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ajb_pkg::CMD_W-1:0]   s_command,
    input  logic [ajb_pkg::LEN_W-1:0]   s_packet_length,
    input  logic [ajb_pkg::REQ_W-1:0]   s_block_size,
    output logic                        q_valid,
    input  logic                        q_pop,
    output ajb_pkg::op_t                q_op
);
    import ajb_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

    op_t               queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    op_t               op_in;
    logic              push;
    logic              pop;

    // classify the incoming transaction
    always_comb begin
        op_in.plen = (32'(s_packet_length) > MAX_PACKET) ? LEN_W'(MAX_PACKET)
                                                          : s_packet_length;
        op_in.req  = s_block_size;
        unique case (command_t'(s_command))
            CMD_PUT:   op_in.kind = (s_packet_length == '0) ? OP_PUT_EMPTY : OP_PUT;
            CMD_READ:  op_in.kind = (s_block_size == '0) ? OP_READ_EMPTY : OP_READ;
            CMD_START: op_in.kind = OP_START;
            CMD_STOP:  op_in.kind = OP_STOP;
        endcase
    end

    assign s_ready = (count_reg != QCNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_op    = queue_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

FILE: hw/rtl/ajb_back.sv
module ajb_back #(
    parameter int RING_DEPTH = ajb_pkg::RING_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  ajb_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  ajb_pkg::op_t  q_op,
    output logic          q_pop,
    output logic          res_valid,
    output ajb_pkg::res_t res,
    input  logic          res_ready
);
    import ajb_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

    bk_state_t              state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic [DEPTH_W-1:0]     target_depth_reg, target_depth_next;
    logic [DEPTH_W-1:0]     bytes_held_reg, bytes_held_next;
    logic [PTR_W-1:0]       head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0]       tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [LEN_W-1:0]       head_consumed_reg, head_consumed_next;
    op_t                    op_reg, op_next;
    logic                   dropped_reg, dropped_next;
    logic [DROP_W-1:0]      drop_left_reg, drop_left_next;
    logic [REQ_W-1:0]       done_reg, done_next;
    logic [SEG_CNT_W-1:0]   seg_cnt_reg, seg_cnt_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [QUOT_FULL_W-1:0] quot_full_reg, quot_full_next;

    logic [LEN_W-1:0]       ring_mem [RING_DEPTH];
    logic [LEN_W-1:0]       rd_data_reg;
    logic                   ring_we;

    logic [PTR_W-1:0]       head_inc;
    logic [PTR_W-1:0]       tail_inc;
    logic                   ring_full;
    logic [LEN_W-1:0]       rem;
    logic [REQ_W:0]         done_plus_rem;
    logic [REQ_W:0]         done_plus_size;
    logic                   seg_fits;
    logic                   seg_more;
    logic [LEN_W-1:0]       seg_size;
    logic [DEPTH_W-1:0]     bytes_after_rem;
    logic [DEPTH_W-1:0]     bytes_after_seg;
    logic [DEPTH_W-1:0]     bytes_after_put;
    mode_t                  mode_put;
    logic [GROWN_W-1:0]     grown;
    logic [DROP_W-1:0]      drop_cap;
    logic [DROP_W-1:0]      drop_first;
    logic                   req_short;

    assign head_inc  = (head_ptr_reg == PTR_LAST) ? '0 : head_ptr_reg + 1'b1;
    assign tail_inc  = (tail_ptr_reg == PTR_LAST) ? '0 : tail_ptr_reg + 1'b1;
    assign ring_full = (count_reg == CNT_FULL);
    assign req_short = (DEPTH_W'(op_reg.req) > bytes_held_reg);

    // unread bytes of the head packet
    assign rem = (rd_data_reg > head_consumed_reg) ? rd_data_reg - head_consumed_reg : '0;

    assign done_plus_rem  = (REQ_W + 1)'(done_reg) + (REQ_W + 1)'(rem);
    assign seg_fits       = (done_plus_rem <= (REQ_W + 1)'(op_reg.req));
    assign seg_size       = seg_fits ? rem : LEN_W'(op_reg.req - done_reg);
    assign done_plus_size = (REQ_W + 1)'(done_reg) + (REQ_W + 1)'(seg_size);
    assign seg_more       = (done_plus_size < (REQ_W + 1)'(op_reg.req))
                            && (seg_fits ? (count_reg != CNT_W'(1)) : (count_reg != '0))
                            && ((32'(seg_cnt_reg) + 32'd1) < MAX_RESULTS);

    assign bytes_after_rem = (DEPTH_W'(rem) > bytes_held_reg) ? '0
                             : bytes_held_reg - DEPTH_W'(rem);
    assign bytes_after_seg = (DEPTH_W'(seg_size) > bytes_held_reg) ? '0
                             : bytes_held_reg - DEPTH_W'(seg_size);
    assign bytes_after_put = bytes_held_reg + DEPTH_W'(op_reg.plen);
    assign mode_put = (((mode_reg == MODE_FIRST_BUF) || (mode_reg == MODE_BUFFERING))
                       && (bytes_after_put >= target_depth_reg)) ? MODE_SENDING : mode_reg;

    assign grown = GROWN_W'(target_depth_reg)
                   + GROWN_W'(quot_full_reg[QUOT_FULL_W-1 -: QUOT_W]);

    assign drop_cap   = (32'(cfg.drop_count) > RING_DEPTH) ? DROP_W'(RING_DEPTH)
                                                           : cfg.drop_count;
    assign drop_first = (drop_cap == '0) ? DROP_W'(1) : drop_cap;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (res_ready) begin
                    unique case (op_reg.kind)
                        OP_PUT: begin
                            if (mode_reg == MODE_INACTIVE) begin
                                state_next = BK_IDLE;
                            end else if (ring_full) begin
                                state_next = BK_DROP_RD;
                            end else begin
                                state_next = BK_STORE;
                            end
                        end
                        OP_READ: begin
                            if (mode_reg != MODE_SENDING) begin
                                state_next = BK_IDLE;
                            end else if (req_short) begin
                                state_next = BK_UND_MUL;
                            end else if (count_reg != '0) begin
                                state_next = BK_SEG_RD;
                            end else begin
                                state_next = BK_IDLE;
                            end
                        end
                        OP_PUT_EMPTY, OP_READ_EMPTY, OP_START, OP_STOP: begin
                            state_next = BK_IDLE;
                        end
                        default: state_next = BK_IDLE;
                    endcase
                end
            end
            BK_DROP_RD:  state_next = BK_DROP_UPD;
            BK_DROP_UPD: state_next = (drop_left_reg <= DROP_W'(1)) ? BK_STORE : BK_DROP_RD;
            BK_STORE: begin
                if (res_ready) begin
                    state_next = BK_IDLE;
                end
            end
            BK_SEG_RD:   state_next = BK_SEG_EMIT;
            BK_SEG_EMIT: begin
                if (res_ready) begin
                    state_next = seg_more ? BK_SEG_RD : BK_IDLE;
                end
            end
            BK_UND_MUL:  state_next = BK_UND_DIV;
            BK_UND_DIV:  state_next = BK_UND_APPLY;
            BK_UND_APPLY: begin
                if (res_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        mode_next          = mode_reg;
        target_depth_next  = target_depth_reg;
        bytes_held_next    = bytes_held_reg;
        head_ptr_next      = head_ptr_reg;
        tail_ptr_next      = tail_ptr_reg;
        count_next         = count_reg;
        head_consumed_next = head_consumed_reg;
        op_next            = op_reg;
        dropped_next       = dropped_reg;
        drop_left_next     = drop_left_reg;
        done_next          = done_reg;
        seg_cnt_next       = seg_cnt_reg;
        prod_next          = prod_reg;
        quot_full_next     = quot_full_reg;
        ring_we            = 1'b0;
        q_pop              = 1'b0;
        res_valid          = 1'b0;
        res                = '0;
        res.status         = ST_IGNORED;
        res.out_slot       = cfg.time_slot;
        res.buffer_state   = mode_reg;
        res.last           = 1'b1;

        unique case (state_reg)
            BK_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    op_next      = q_op;
                    dropped_next = 1'b0;
                end
            end
            BK_EXEC: begin
                unique case (op_reg.kind)
                    OP_PUT: begin
                        if (mode_reg == MODE_INACTIVE) begin
                            res_valid = 1'b1;
                        end else if (ring_full && res_ready) begin
                            drop_left_next = drop_first;
                            dropped_next   = 1'b1;
                        end
                    end
                    OP_PUT_EMPTY: begin
                        res_valid = 1'b1;
                    end
                    OP_READ, OP_READ_EMPTY: begin
                        if (mode_reg != MODE_SENDING) begin
                            res_valid  = 1'b1;
                            res.status = ST_NOT_SENDING;
                        end else if ((op_reg.kind == OP_READ) && req_short) begin
                            res_valid = 1'b0;
                        end else if ((op_reg.kind == OP_READ) && (count_reg != '0)) begin
                            if (res_ready) begin
                                done_next    = '0;
                                seg_cnt_next = '0;
                            end
                        end else begin
                            // empty block or empty ring: one zero-length segment
                            res_valid         = 1'b1;
                            res.status        = ST_SEGMENT;
                            res.slot_index    = SLOT_W'(head_ptr_reg);
                            res.source_offset = head_consumed_reg;
                        end
                    end
                    OP_START: begin
                        res_valid        = 1'b1;
                        res.status       = ST_STARTED;
                        res.buffer_state = MODE_FIRST_BUF;
                        if (res_ready) begin
                            head_ptr_next      = '0;
                            tail_ptr_next      = '0;
                            count_next         = '0;
                            head_consumed_next = '0;
                            bytes_held_next    = '0;
                            target_depth_next  = cfg.min_depth;
                            mode_next          = MODE_FIRST_BUF;
                        end
                    end
                    OP_STOP: begin
                        res_valid        = 1'b1;
                        res.status       = ST_STOPPED;
                        res.buffer_state = MODE_INACTIVE;
                        if (res_ready) begin
                            head_ptr_next      = '0;
                            tail_ptr_next      = '0;
                            count_next         = '0;
                            head_consumed_next = '0;
                            bytes_held_next    = '0;
                            mode_next          = MODE_INACTIVE;
                        end
                    end
                    default: res_valid = 1'b0;
                endcase
            end
            BK_DROP_RD: begin
                res_valid = 1'b0;
            end
            BK_DROP_UPD: begin
                bytes_held_next    = bytes_after_rem;
                head_ptr_next      = head_inc;
                head_consumed_next = '0;
                count_next         = count_reg - 1'b1;
                drop_left_next     = drop_left_reg - 1'b1;
            end
            BK_STORE: begin
                res_valid        = 1'b1;
                res.status       = dropped_reg ? ST_STORED_DROP : ST_STORED;
                res.slot_index   = SLOT_W'(tail_ptr_reg);
                res.buffer_state = mode_put;
                if (res_ready) begin
                    ring_we         = 1'b1;
                    tail_ptr_next   = tail_inc;
                    count_next      = count_reg + 1'b1;
                    bytes_held_next = bytes_after_put;
                    mode_next       = mode_put;
                end
            end
            BK_SEG_RD: begin
                res_valid = 1'b0;
            end
            BK_SEG_EMIT: begin
                res_valid          = 1'b1;
                res.status         = ST_SEGMENT;
                res.slot_index     = SLOT_W'(head_ptr_reg);
                res.source_offset  = head_consumed_reg;
                res.dest_offset    = done_reg;
                res.segment_length = seg_size;
                res.last           = !seg_more;
                if (res_ready) begin
                    if (seg_fits) begin
                        head_ptr_next      = head_inc;
                        head_consumed_next = '0;
                        count_next         = count_reg - 1'b1;
                    end else begin
                        head_consumed_next = head_consumed_reg + seg_size;
                    end
                    done_next       = done_plus_size[REQ_W-1:0];
                    bytes_held_next = bytes_after_seg;
                    seg_cnt_next    = seg_cnt_reg + 1'b1;
                end
            end
            BK_UND_MUL: begin
                prod_next = PROD_W'(target_depth_reg) * PROD_W'(cfg.upscale_percent);
            end
            BK_UND_DIV: begin
                quot_full_next = QUOT_FULL_W'(prod_reg) * QUOT_FULL_W'(PCT_RECIP);
            end
            BK_UND_APPLY: begin
                res_valid        = 1'b1;
                res.status       = ST_UNDERRUN;
                res.buffer_state = MODE_BUFFERING;
                if (res_ready) begin
                    if (grown <= GROWN_W'(cfg.max_depth)) begin
                        target_depth_next = DEPTH_W'(grown);
                    end
                    mode_next = MODE_BUFFERING;
                end
            end
            default: res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= BK_IDLE;
            mode_reg          <= MODE_INACTIVE;
            target_depth_reg  <= '0;
            bytes_held_reg    <= '0;
            head_ptr_reg      <= '0;
            tail_ptr_reg      <= '0;
            count_reg         <= '0;
            head_consumed_reg <= '0;
            dropped_reg       <= 1'b0;
            drop_left_reg     <= '0;
            done_reg          <= '0;
            seg_cnt_reg       <= '0;
        end else begin
            state_reg         <= state_next;
            mode_reg          <= mode_next;
            target_depth_reg  <= target_depth_next;
            bytes_held_reg    <= bytes_held_next;
            head_ptr_reg      <= head_ptr_next;
            tail_ptr_reg      <= tail_ptr_next;
            count_reg         <= count_next;
            head_consumed_reg <= head_consumed_next;
            dropped_reg       <= dropped_next;
            drop_left_reg     <= drop_left_next;
            done_reg          <= done_next;
            seg_cnt_reg       <= seg_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        prod_reg      <= prod_next;
        quot_full_reg <= quot_full_next;
    end

    // length ring
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[tail_ptr_reg] <= op_reg.plen;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= ring_mem[head_ptr_reg];
    end

endmodule

FILE: hw/rtl/ajb_out.sv
module ajb_out (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          res_valid,
    input  ajb_pkg::res_t res_in,
    output logic          res_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output ajb_pkg::res_t m_res
);
    import ajb_pkg::*;

    logic m_valid_reg, m_valid_next;
    res_t res_reg, res_next;

    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_res     = res_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                res_next = res_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

FILE: hw/rtl/adaptive_jitter_buffer_ctrl_core.sv
// start, stop and ignored or refused commands are answered from the execute state; a put
// first retires one ring entry per dropped packet, an underrun passes a multiply and a
// divide step, and each segment of a read first waits for a ring read port access
// commands execute one at a time; later ones are accepted into the front queue while it has room
// reset: synchronous active-low aresetn clears control state and loads register defaults;
// the length ring is not cleared and holds no valid bits
module adaptive_jitter_buffer_ctrl_core #(
    parameter int RING_DEPTH = ajb_pkg::RING_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ajb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ajb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ajb_pkg::CMD_W-1:0]        s_command,
    input  logic [ajb_pkg::LEN_W-1:0]        s_packet_length,
    input  logic [ajb_pkg::REQ_W-1:0]        s_block_size,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ajb_pkg::STATUS_W-1:0]     m_status,
    output logic [ajb_pkg::SLOT_W-1:0]       m_slot_index,
    output logic [ajb_pkg::LEN_W-1:0]        m_source_offset,
    output logic [ajb_pkg::REQ_W-1:0]        m_dest_offset,
    output logic [ajb_pkg::LEN_W-1:0]        m_segment_length,
    output logic [ajb_pkg::TSLOT_W-1:0]      m_out_slot,
    output logic [ajb_pkg::MODE_W-1:0]       m_buffer_state,
    output logic                             m_last
);
    import ajb_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic q_valid;
    logic q_pop;
    op_t  q_op;
    logic res_valid;
    logic res_ready;
    res_t res;
    res_t m_res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_MIN_DEPTH:  cfg_next.min_depth       = cfg_wdata;
                CFG_MAX_DEPTH:  cfg_next.max_depth       = cfg_wdata;
                CFG_UPSCALE:    cfg_next.upscale_percent = cfg_wdata[PCT_W-1:0];
                CFG_DROP_COUNT: cfg_next.drop_count      = cfg_wdata[DROP_W-1:0];
                CFG_TIME_SLOT:  cfg_next.time_slot       = cfg_wdata[TSLOT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_depth       <= MIN_DEPTH_RST;
            cfg_reg.max_depth       <= MAX_DEPTH_RST;
            cfg_reg.upscale_percent <= UPSCALE_RST;
            cfg_reg.drop_count      <= DROP_RST;
            cfg_reg.time_slot       <= TSLOT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ajb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_packet_length (s_packet_length),
        .s_block_size    (s_block_size),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_op            (q_op)
    );

    ajb_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    ajb_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_in    (res),
        .res_ready (res_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_status         = m_res.status;
    assign m_slot_index     = m_res.slot_index;
    assign m_source_offset  = m_res.source_offset;
    assign m_dest_offset    = m_res.dest_offset;
    assign m_segment_length = m_res.segment_length;
    assign m_out_slot       = m_res.out_slot;
    assign m_buffer_state   = m_res.buffer_state;
    assign m_last           = m_res.last;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_SEGMENT)) |-> m_last)
        else $error("single-result transaction without last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_SEGMENT)) |-> (m_buffer_state == MODE_SENDING))
        else $error("segment emitted outside sending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_STARTED)) |-> (m_buffer_state == MODE_FIRST_BUF))
        else $error("start did not enter first buffering");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_SEGMENT))
            |-> ((m_segment_length == '0) && (m_dest_offset == '0)))
        else $error("non-segment result carries segment data");
`endif

endmodule

FILE: bench/tb_adaptive_jitter_buffer_ctrl_core.sv
module tb_adaptive_jitter_buffer_ctrl_core;
    import ajb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned TAIL_CYCLES = 40;

    typedef struct {
        command_t          cmd;
        logic [LEN_W-1:0]  plen;
        logic [REQ_W-1:0]  req;
    } command_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CMD_W-1:0] s_command = '0;
    logic [LEN_W-1:0] s_packet_length = '0;
    logic [REQ_W-1:0] s_block_size = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [SLOT_W-1:0] m_slot_index;
    logic [LEN_W-1:0] m_source_offset;
    logic [REQ_W-1:0] m_dest_offset;
    logic [LEN_W-1:0] m_segment_length;
    logic [TSLOT_W-1:0] m_out_slot;
    logic [MODE_W-1:0] m_buffer_state;
    logic m_last;

    adaptive_jitter_buffer_ctrl_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_packet_length  (s_packet_length),
        .s_block_size     (s_block_size),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_slot_index     (m_slot_index),
        .m_source_offset  (m_source_offset),
        .m_dest_offset    (m_dest_offset),
        .m_segment_length (m_segment_length),
        .m_out_slot       (m_out_slot),
        .m_buffer_state   (m_buffer_state),
        .m_last           (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // buffer controller shadow state
    logic [DEPTH_W-1:0] min_depth_q = MIN_DEPTH_RST;
    logic [DEPTH_W-1:0] max_depth_q = MAX_DEPTH_RST;
    logic [PCT_W-1:0]   upscale_q   = UPSCALE_RST;
    logic [DROP_W-1:0]  drop_q      = DROP_RST;
    logic [TSLOT_W-1:0] tslot_q     = TSLOT_RST;

    mode_t              buf_mode     = MODE_INACTIVE;
    logic [DEPTH_W-1:0] depth_target = '0;
    logic [DEPTH_W-1:0] held_bytes   = '0;
    logic [LEN_W-1:0]   ring_len [RING_DEPTH_DEF];
    logic [SLOT_W-1:0]  head_idx     = '0;
    logic [SLOT_W-1:0]  tail_idx     = '0;
    int unsigned        pkt_count    = 0;
    logic [LEN_W-1:0]   head_used    = '0;

    command_item_t pending_commands [$];
    res_t          expected_results [$];

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int          idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned send_gap = 0;
    logic        in_fire = 1'b0;
    command_item_t next_item;

    function automatic int unsigned head_left();
        return (ring_len[head_idx] > head_used) ? int'(ring_len[head_idx] - head_used) : 0;
    endfunction

    function automatic void consume_bytes(input int unsigned n);
        held_bytes = (n > held_bytes) ? '0 : held_bytes - DEPTH_W'(n);
    endfunction

    function automatic void pop_oldest();
        head_idx = head_idx + 1'b1;
        head_used = '0;
        if (pkt_count > 0) pkt_count--;
    endfunction

    function automatic void clear_ring();
        head_idx = '0;
        tail_idx = '0;
        pkt_count = 0;
        head_used = '0;
        held_bytes = '0;
    endfunction

    task automatic predict_step(input command_t cmd, input logic [LEN_W-1:0] plen,
                                input logic [REQ_W-1:0] req);
        res_t outs [$];
        res_t r;
        int unsigned drops, done, remain, size, grown;
        status_t put_status;
        r = '0;
        r.out_slot = tslot_q;
        case (cmd)
            CMD_PUT: begin
                if (buf_mode == MODE_INACTIVE || plen == 0) begin
                    r.status = ST_IGNORED;
                    outs.push_back(r);
                end else begin
                    put_status = ST_STORED;
                    if (pkt_count >= RING_DEPTH_DEF) begin
                        drops = drop_q;
                        if (drops > pkt_count) drops = pkt_count;
                        if (drops == 0) drops = 1;
                        repeat (drops) begin
                            consume_bytes(head_left());
                            pop_oldest();
                        end
                        put_status = ST_STORED_DROP;
                    end
                    ring_len[tail_idx] = plen;
                    r.slot_index = tail_idx;
                    tail_idx = tail_idx + 1'b1;
                    pkt_count++;
                    held_bytes = held_bytes + DEPTH_W'(plen);
                    if ((buf_mode == MODE_BUFFERING || buf_mode == MODE_FIRST_BUF) &&
                        held_bytes >= depth_target)
                        buf_mode = MODE_SENDING;
                    r.status = put_status;
                    outs.push_back(r);
                end
            end
            CMD_READ: begin
                if (buf_mode != MODE_SENDING) begin
                    r.status = ST_NOT_SENDING;
                    outs.push_back(r);
                end else if (req > held_bytes) begin
                    grown = 32'(depth_target) +
                            (32'(depth_target) * 32'(upscale_q)) / 32'(PERCENT_BASE);
                    if (grown <= max_depth_q) depth_target = DEPTH_W'(grown);
                    buf_mode = MODE_BUFFERING;
                    r.status = ST_UNDERRUN;
                    outs.push_back(r);
                end else begin
                    done = 0;
                    while (done < req && pkt_count > 0 && outs.size() < MAX_RESULTS) begin
                        remain = head_left();
                        r.status = ST_SEGMENT;
                        r.slot_index = head_idx;
                        r.source_offset = head_used;
                        r.dest_offset = REQ_W'(done);
                        if (done + remain <= req) begin
                            size = remain;
                            pop_oldest();
                        end else begin
                            size = req - done;
                            head_used = head_used + LEN_W'(size);
                        end
                        r.segment_length = LEN_W'(size);
                        outs.push_back(r);
                        done += size;
                        consume_bytes(size);
                    end
                    // zero-size block or nothing to take: one empty segment at the head
                    if (outs.size() == 0) begin
                        r.status = ST_SEGMENT;
                        r.slot_index = head_idx;
                        r.source_offset = head_used;
                        outs.push_back(r);
                    end
                end
            end
            CMD_START: begin
                clear_ring();
                depth_target = min_depth_q;
                buf_mode = MODE_FIRST_BUF;
                r.status = ST_STARTED;
                outs.push_back(r);
            end
            default: begin
                clear_ring();
                buf_mode = MODE_INACTIVE;
                r.status = ST_STOPPED;
                outs.push_back(r);
            end
        endcase
        foreach (outs[k]) outs[k].buffer_state = buf_mode;
        outs[outs.size()-1].last = 1'b1;
        foreach (outs[k]) expected_results.push_back(outs[k]);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // input acceptance and result checking
    always @(posedge aclk) begin : monitor_proc
        res_t want;
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready)
                predict_step(command_t'(s_command), s_packet_length, s_block_size);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual status %0d",
                             $time, m_status);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("slot_index", want.slot_index, m_slot_index);
                    check_field("source_offset", want.source_offset, m_source_offset);
                    check_field("dest_offset", want.dest_offset, m_dest_offset);
                    check_field("segment_length", want.segment_length, m_segment_length);
                    check_field("out_slot", want.out_slot, m_out_slot);
                    check_field("buffer_state", want.buffer_state, m_buffer_state);
                    check_field("last", want.last, m_last);
                end
            end
        end
    end

    // command driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_fire) begin
                if (in_fire && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                    send_gap = $urandom_range(1, 8);
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_commands.size() > 0) begin
                    next_item = pending_commands.pop_front();
                    s_command <= next_item.cmd;
                    s_packet_length <= next_item.plen;
                    s_block_size <= next_item.req;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_command(input command_t c, input int unsigned plen,
                                input int unsigned req);
        command_item_t item;
        item.cmd = c;
        item.plen = LEN_W'(plen);
        item.req = REQ_W'(req);
        pending_commands.push_back(item);
    endtask

    task automatic wait_drained();
        while (pending_commands.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MIN_DEPTH:  min_depth_q = val;
            CFG_MAX_DEPTH:  max_depth_q = val;
            CFG_UPSCALE:    upscale_q = val[PCT_W-1:0];
            CFG_DROP_COUNT: drop_q = val[DROP_W-1:0];
            default:        tslot_q = val[TSLOT_W-1:0];
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_config(input int unsigned min_d, input int unsigned max_d,
                               input int unsigned pct, input int unsigned drop,
                               input int unsigned slot);
        write_reg(CFG_MIN_DEPTH, CFG_DATA_W'(min_d));
        write_reg(CFG_MAX_DEPTH, CFG_DATA_W'(max_d));
        write_reg(CFG_UPSCALE, CFG_DATA_W'(pct));
        write_reg(CFG_DROP_COUNT, CFG_DATA_W'(drop));
        write_reg(CFG_TIME_SLOT, CFG_DATA_W'(slot));
    endtask

    // a session opens with start, then a weighted mix with some zero-size noise
    task automatic run_phase(input int unsigned count, input int unsigned put_w,
                             input int unsigned read_w, input int idle);
        int unsigned i, pick, sel, plen_v, req_v;
        idle_pct = idle;
        push_command(CMD_START, 0, 0);
        for (i = 1; i < count; i++) begin
            pick = $urandom_range(0, 99);
            sel = $urandom_range(0, 31);
            plen_v = (sel == 0) ? 0 : (sel < 8) ? $urandom_range(1, 2047)
                                               : $urandom_range(1, 300);
            req_v = (sel == 1) ? 0 : (sel < 6) ? $urandom_range(1, 4095)
                                              : $urandom_range(1, 500);
            if (pick < put_w)
                push_command(CMD_PUT, plen_v, $urandom_range(0, 4095));
            else if (pick < put_w + read_w)
                push_command(CMD_READ, $urandom_range(0, 2047), req_v);
            else if (pick < put_w + read_w + (100 - put_w - read_w) / 2)
                push_command(CMD_START, plen_v, req_v);
            else
                push_command(CMD_STOP, plen_v, req_v);
        end
        wait_drained();
    endtask

    initial begin
        int unsigned k;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        idle_pct = 20;
        push_command(CMD_PUT, 5, 0);
        push_command(CMD_READ, 0, 10);
        push_command(CMD_STOP, 0, 0);
        push_command(CMD_START, 0, 0);
        push_command(CMD_PUT, 0, 0);
        push_command(CMD_READ, 0, 1);
        push_command(CMD_PUT, 2047, 0);
        push_command(CMD_READ, 0, 0);
        push_command(CMD_READ, 0, 4095);
        push_command(CMD_READ, 0, 5);
        push_command(CMD_PUT, 1, 4095);
        push_command(CMD_READ, 2047, 100);
        push_command(CMD_READ, 0, 1948);
        push_command(CMD_READ, 0, 1);
        push_command(CMD_PUT, 1, 0);
        push_command(CMD_START, 0, 0);
        push_command(CMD_PUT, 160, 0);
        push_command(CMD_PUT, 3, 0);
        push_command(CMD_READ, 0, 163);
        push_command(CMD_STOP, 0, 0);
        wait_drained();

        load_config(0, 65535, 255, 16, 31);
        run_phase(70, 55, 38, 30);

        load_config(65535, 65535, 0, 0, 0);
        run_phase(50, 85, 12, 10);

        // receiver holds off while the sender keeps offering
        load_config(200, 0, 100, 1, 17);
        hold_requests++;
        run_phase(60, 55, 38, 20);

        for (k = 0; k < 4; k++) begin
            load_config($urandom_range(0, 3000),
                        ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 4000),
                        $urandom_range(0, 255), $urandom_range(0, 16),
                        $urandom_range(0, 31));
            run_phase(60, (k % 2) ? 80 : 55, (k % 2) ? 17 : 38,
                      (k == 3) ? 0 : $urandom_range(5, 40));
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("[adaptive_jitter_buffer_ctrl_core] OK");
        else
            $display("[adaptive_jitter_buffer_ctrl_core] ERROR");
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("%0t: timeout", $time);
        $display("[adaptive_jitter_buffer_ctrl_core] ERROR");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ajb_pkg.sv
hw/rtl/ajb_front.sv
hw/rtl/ajb_back.sv
hw/rtl/ajb_out.sv
hw/rtl/adaptive_jitter_buffer_ctrl_core.sv
bench/tb_adaptive_jitter_buffer_ctrl_core.sv
